[design/apsp_pkg.sv]
// Package for the all-pairs shortest path core.
// Holds field widths, action and register codes, and distance constants.
// No dependencies.
`default_nettype none

package apsp_pkg;

    localparam int ACTION_W     = 2;
    localparam int VERTEX_W     = 6;
    localparam int WEIGHT_W     = 16;
    localparam int DIST_W       = 32;
    localparam int VC_W         = 7;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 7;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 4096;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTED     = 1'b1;

    localparam logic KIND_READ    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    localparam logic signed [DIST_W-1:0] INF_DIST = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W:0]   MIN_SUM  = 33'sh1_8000_0000;

endpackage

`default_nettype wire

[design/all_pairs_shortest_path_core.sv]
// All-pairs shortest path core: edge store, Floyd-Warshall sequencer, read port.
// Two on-chip memories (direct weights, path lengths) and one add/compare unit for relaxation.
// Depends on apsp_pkg.
//
// Channel  Direction  Handshake              Payload
// s_       in         s_valid / s_ready      action, src_vertex, dst_vertex, weight
// m_       out        m_valid / m_ready      kind, distance, unreachable, negative_cycle
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An add on an undirected graph also writes the reverse edge while an edge slot is free.
// Compute with n vertices builds the path table, relaxes it through each k and checks the
// diagonal, through the path memory's two read ports and the single sum/compare unit.
// Reset: a sweep over every cell fills both memories with infinity; no input
// transfer is taken meanwhile, configuration writes are.
// A pending result in the output register only stalls an item that has its own result.
`default_nettype none

module all_pairs_shortest_path_core #(
    parameter int MAX_VERTICES = apsp_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = apsp_pkg::DEF_MAX_EDGES
) (
    input  wire  logic                                 aclk,
    input  wire  logic                                 aresetn,
    input  wire  logic                                 s_valid,
    output logic                                       s_ready,
    input  wire  logic [apsp_pkg::ACTION_W-1:0]        s_action,
    input  wire  logic [apsp_pkg::VERTEX_W-1:0]        s_src_vertex,
    input  wire  logic [apsp_pkg::VERTEX_W-1:0]        s_dst_vertex,
    input  wire  logic signed [apsp_pkg::WEIGHT_W-1:0] s_weight,
    output logic                                       m_valid,
    input  wire  logic                                 m_ready,
    output logic                                       m_kind,
    output logic signed [apsp_pkg::DIST_W-1:0]         m_distance,
    output logic                                       m_unreachable,
    output logic                                       m_negative_cycle,
    input  wire  logic                                 cfg_valid,
    output logic                                       cfg_ready,
    input  wire  logic [apsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  logic [apsp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import apsp_pkg::*;

    localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(CELLS);
    localparam int VMAX  = (MAX_VERTICES > 127) ? 127 : MAX_VERTICES;
    localparam int CW    = $clog2(VMAX + 1);
    localparam int EW    = $clog2(MAX_EDGES + 1);

    typedef enum logic [12:0] {
        ST_INIT    = 13'b0000000000001,
        ST_IDLE    = 13'b0000000000010,
        ST_CLR     = 13'b0000000000100,
        ST_ADD_RD  = 13'b0000000001000,
        ST_ADD_WR  = 13'b0000000010000,
        ST_BLD_RD  = 13'b0000000100000,
        ST_BLD_WR  = 13'b0000001000000,
        ST_FW_RD   = 13'b0000010000000,
        ST_FW_SUM  = 13'b0000100000000,
        ST_FW_WR   = 13'b0001000000000,
        ST_CHK_RD  = 13'b0010000000000,
        ST_CHK_EV  = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [VC_W-1:0] row,
                                                input logic [VC_W-1:0] col);
        return AW'(AW'(row) * AW'(MAX_VERTICES) + AW'(col));
    endfunction

    // memories
    logic signed [DIST_W-1:0] dw_mem [CELLS];
    logic signed [DIST_W-1:0] pm_mem [CELLS];
    logic signed [DIST_W-1:0] dw_rdata0, dw_rdata1, pm_rdata0, pm_rdata1;
    logic [AW-1:0]            dw_raddr0, dw_raddr1, pm_raddr0, pm_raddr1;
    logic [AW-1:0]            dw_waddr, pm_waddr;
    logic signed [DIST_W-1:0] dw_wdata, pm_wdata;
    logic                     dw_we, pm_we;

    // control
    state_t          state_reg, state_next;
    logic [CW-1:0]   vc_reg, vc_next;
    logic            dir_reg, dir_next;
    logic [EW-1:0]   slots_reg, slots_next;
    logic            cycle_reg, cycle_next;
    logic            rev_reg, rev_next;
    logic [CW-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            m_valid_reg, m_valid_next;

    // payload
    logic [VERTEX_W-1:0]        u_reg, u_next, v_reg, v_next;
    logic signed [WEIGHT_W-1:0] w_reg, w_next;
    logic                       oob_reg, oob_next;
    logic signed [DIST_W:0]     sum_reg, sum_next;
    logic                       sum_ok_reg, sum_ok_next;
    logic                       m_kind_reg, m_kind_next;
    logic signed [DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic                       m_unr_reg, m_unr_next;
    logic                       m_neg_reg, m_neg_next;

    logic                     s_xfer, out_free, in_oob;
    logic [CW-1:0]            last;
    logic                     i_last, j_last, k_last;
    logic signed [DIST_W-1:0] w_ext, bld_d;
    logic signed [DIST_W:0]   sum_raw;
    logic [EW:0]              slots_inc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_distance       = m_dist_reg;
    assign m_unreachable    = m_unr_reg;
    assign m_negative_cycle = m_neg_reg;

    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_oob   = ({1'b0, s_src_vertex} >= VC_W'(vc_reg))
                   || ({1'b0, s_dst_vertex} >= VC_W'(vc_reg));
    assign last     = vc_reg - CW'(1);
    assign i_last   = (i_reg == last);
    assign j_last   = (j_reg == last);
    assign k_last   = (k_reg == last);
    assign w_ext    = {{(DIST_W-WEIGHT_W){w_reg[WEIGHT_W-1]}}, w_reg};
    assign slots_inc = {1'b0, slots_reg} + (EW+1)'(1);

    always_comb begin
        sum_raw = {pm_rdata0[DIST_W-1], pm_rdata0} + {pm_rdata1[DIST_W-1], pm_rdata1};
        if (sum_raw < MIN_SUM) begin
            sum_raw = MIN_SUM;
        end
    end

    always_comb begin
        bld_d = (i_reg == j_reg) ? '0 : INF_DIST;
        if (dw_rdata0 < bld_d) begin
            bld_d = dw_rdata0;
        end
        if (!dir_reg && (dw_rdata1 < bld_d)) begin
            bld_d = dw_rdata1;
        end
    end

    // read addresses
    always_comb begin
        dw_raddr1 = cell_addr(VC_W'(j_reg), VC_W'(i_reg));
        pm_raddr1 = cell_addr(VC_W'(k_reg), VC_W'(j_reg));
        case (state_reg)
            ST_IDLE: begin
                dw_raddr0 = cell_addr(VC_W'(s_src_vertex), VC_W'(s_dst_vertex));
                pm_raddr0 = cell_addr(VC_W'(s_src_vertex), VC_W'(s_dst_vertex));
            end
            ST_ADD_RD, ST_ADD_WR: begin
                dw_raddr0 = rev_reg ? cell_addr(VC_W'(v_reg), VC_W'(u_reg))
                                    : cell_addr(VC_W'(u_reg), VC_W'(v_reg));
                pm_raddr0 = cell_addr(VC_W'(u_reg), VC_W'(v_reg));
            end
            ST_FW_RD: begin
                dw_raddr0 = cell_addr(VC_W'(i_reg), VC_W'(j_reg));
                pm_raddr0 = cell_addr(VC_W'(i_reg), VC_W'(k_reg));
            end
            ST_CHK_RD: begin
                dw_raddr0 = cell_addr(VC_W'(i_reg), VC_W'(j_reg));
                pm_raddr0 = cell_addr(VC_W'(i_reg), VC_W'(i_reg));
            end
            ST_DONE: begin
                dw_raddr0 = cell_addr(VC_W'(i_reg), VC_W'(j_reg));
                pm_raddr0 = cell_addr(VC_W'(u_reg), VC_W'(v_reg));
            end
            default: begin
                dw_raddr0 = cell_addr(VC_W'(i_reg), VC_W'(j_reg));
                pm_raddr0 = cell_addr(VC_W'(i_reg), VC_W'(j_reg));
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        vc_next      = vc_reg;
        dir_next     = dir_reg;
        slots_next   = slots_reg;
        cycle_next   = cycle_reg;
        rev_next     = rev_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        w_next       = w_reg;
        oob_next     = oob_reg;
        sum_next     = sum_reg;
        sum_ok_next  = sum_ok_reg;
        m_kind_next  = m_kind_reg;
        m_dist_next  = m_dist_reg;
        m_unr_next   = m_unr_reg;
        m_neg_next   = m_neg_reg;
        dw_we        = 1'b0;
        dw_waddr     = clr_reg;
        dw_wdata     = INF_DIST;
        pm_we        = 1'b0;
        pm_waddr     = clr_reg;
        pm_wdata     = INF_DIST;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_VERTEX_COUNT) begin
                vc_next = (cfg_data > CFG_DATA_W'(VMAX)) ? CW'(VMAX) : CW'(cfg_data);
            end else begin
                dir_next = cfg_data[0];
            end
        end

        case (state_reg)
            ST_INIT: begin
                dw_we = 1'b1;
                pm_we = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    u_next   = s_src_vertex;
                    v_next   = s_dst_vertex;
                    w_next   = s_weight;
                    oob_next = in_oob;
                    rev_next = 1'b0;
                    case (action_t'(s_action))
                        ACT_CLEAR: begin
                            slots_next = '0;
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                        ACT_ADD: begin
                            if (!in_oob && (slots_reg < EW'(MAX_EDGES))) begin
                                state_next = ST_ADD_WR;
                            end
                        end
                        ACT_COMPUTE: begin
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                            if (vc_reg == '0) begin
                                cycle_next = 1'b0;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_BLD_RD;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLR: begin
                dw_we = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_RD: begin
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                dw_waddr   = dw_raddr0;
                dw_wdata   = w_ext;
                dw_we      = (w_ext < dw_rdata0);
                slots_next = EW'(slots_inc);
                if (!rev_reg && !dir_reg && (slots_inc < (EW+1)'(MAX_EDGES))) begin
                    rev_next   = 1'b1;
                    state_next = ST_ADD_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLD_RD: begin
                state_next = ST_BLD_WR;
            end
            ST_BLD_WR: begin
                pm_we    = 1'b1;
                pm_waddr = cell_addr(VC_W'(i_reg), VC_W'(j_reg));
                pm_wdata = bld_d;
                state_next = ST_BLD_RD;
                if (j_last) begin
                    j_next = '0;
                    if (i_last) begin
                        i_next     = '0;
                        state_next = ST_FW_RD;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end else begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_FW_RD: begin
                state_next = ST_FW_SUM;
            end
            ST_FW_SUM: begin
                sum_next    = sum_raw;
                sum_ok_next = (pm_rdata0 != INF_DIST) && (pm_rdata1 != INF_DIST);
                state_next  = ST_FW_WR;
            end
            ST_FW_WR: begin
                pm_waddr = cell_addr(VC_W'(i_reg), VC_W'(j_reg));
                pm_wdata = sum_reg[DIST_W-1:0];
                pm_we    = sum_ok_reg
                        && (sum_reg < $signed({pm_rdata0[DIST_W-1], pm_rdata0}));
                state_next = ST_FW_RD;
                if (j_last) begin
                    j_next = '0;
                    if (i_last) begin
                        i_next = '0;
                        if (k_last) begin
                            cycle_next = 1'b0;
                            state_next = ST_CHK_RD;
                        end else begin
                            k_next = k_reg + CW'(1);
                        end
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end else begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_CHK_RD: begin
                state_next = ST_CHK_EV;
            end
            ST_CHK_EV: begin
                if (pm_rdata0[DIST_W-1]) begin
                    cycle_next = 1'b1;
                end
                if (i_last) begin
                    u_next     = '0;
                    v_next     = '0;
                    w_next     = '0;
                    state_next = ST_DONE;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_CHK_RD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_neg_next   = cycle_reg;
                    if (w_reg == '0 && rev_reg) begin
                        m_kind_next = KIND_READ;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result kind: compute and read both end in ST_DONE, told apart by a flag
    logic is_read_reg, is_read_next;

    always_comb begin
        is_read_next = is_read_reg;
        if (s_xfer) begin
            is_read_next = (action_t'(s_action) == ACT_READ);
        end
    end

    logic signed [DIST_W-1:0] res_dist;
    logic                     res_unr;

    always_comb begin
        if (!is_read_reg) begin
            res_dist = '0;
            res_unr  = 1'b0;
        end else if (oob_reg) begin
            res_dist = INF_DIST;
            res_unr  = 1'b1;
        end else begin
            res_dist = pm_rdata0;
            res_unr  = (pm_rdata0 == INF_DIST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            vc_reg      <= '0;
            dir_reg     <= 1'b0;
            slots_reg   <= '0;
            cycle_reg   <= 1'b0;
            rev_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            is_read_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vc_reg      <= vc_next;
            dir_reg     <= dir_next;
            slots_reg   <= slots_next;
            cycle_reg   <= cycle_next;
            rev_reg     <= rev_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            is_read_reg <= is_read_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg      <= u_next;
        v_reg      <= v_next;
        w_reg      <= w_next;
        oob_reg    <= oob_next;
        sum_reg    <= sum_next;
        sum_ok_reg <= sum_ok_next;
        m_neg_reg  <= m_neg_next;
        if (state_reg == ST_DONE && out_free) begin
            m_kind_reg <= is_read_reg ? KIND_READ : KIND_COMPUTE;
            m_dist_reg <= res_dist;
            m_unr_reg  <= res_unr;
        end else begin
            m_kind_reg <= m_kind_next;
            m_dist_reg <= m_dist_next;
            m_unr_reg  <= m_unr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dw_we) begin
            dw_mem[dw_waddr] <= dw_wdata;
        end
        dw_rdata0 <= dw_mem[dw_raddr0];
        dw_rdata1 <= dw_mem[dw_raddr1];
    end

    always_ff @(posedge aclk) begin
        if (pm_we) begin
            pm_mem[pm_waddr] <= pm_wdata;
        end
        pm_rdata0 <= pm_mem[pm_raddr0];
        pm_rdata1 <= pm_mem[pm_raddr1];
    end

endmodule

`default_nettype wire
